@@ sv/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// shared widths, operation codes and scan status for the lfu cache table
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int STAMP_W   = 48;
   localparam int CAP_CFG_W = 5;
   localparam logic [CAP_CFG_W-1:0] CAP_CFG_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // status of one finished table scan
   typedef struct packed {
      logic hit;
      logic free_found;
      logic victim_found;
   } scan_flags_type;

endpackage

@@ sv/lfu_if.sv @@
// ----------------------------------------------------------------------------
// lfu request and response channels
// valid/ready channels carrying the cache operation and its result
// ----------------------------------------------------------------------------
interface lfu_req_if;
   import lfu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [KEY_W-1:0] key;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, func, key, value, input ready);
   modport sink   (input valid, func, key, value, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;
   logic                    evicted;
   logic signed [KEY_W-1:0] evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

@@ sv/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ sv/lfu_scan.sv @@
// ----------------------------------------------------------------------------
// lfu_scan
// walks the entries one per cycle while cmp_en is high: key match, first free slot, lfu victim
// ----------------------------------------------------------------------------
module lfu_scan #(
   parameter int FREQ_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          cmp_en,
   input  logic [IDX_W-1:0]              cmp_idx,
   input  logic                          cmp_valid,
   input  logic [lfu_pkg::KEY_W-1:0]     cmp_key,
   input  logic [lfu_pkg::VAL_W-1:0]     cmp_value,
   input  logic [FREQ_BITS-1:0]          cmp_freq,
   input  logic [lfu_pkg::STAMP_W-1:0]   cmp_stamp,
   input  logic [lfu_pkg::KEY_W-1:0]     search_key,
   output lfu_pkg::scan_flags_type       flags,
   output logic [IDX_W-1:0]              hit_idx,
   output logic [lfu_pkg::VAL_W-1:0]     hit_value,
   output logic [FREQ_BITS-1:0]          hit_freq,
   output logic [IDX_W-1:0]              free_idx,
   output logic [IDX_W-1:0]              victim_idx,
   output logic [lfu_pkg::KEY_W-1:0]     victim_key
);
   import lfu_pkg::*;

   scan_flags_type       flags_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [VAL_W-1:0]     hit_value_ff;
   logic [FREQ_BITS-1:0] hit_freq_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic [IDX_W-1:0]     victim_idx_ff;
   logic [KEY_W-1:0]     victim_key_ff;
   logic [FREQ_BITS-1:0] best_freq_ff;
   logic [STAMP_W-1:0]   best_stamp_ff;
   logic                 better;

   // lower frequency wins, then the older stamp
   assign better = !flags_ff.victim_found || (cmp_freq < best_freq_ff) ||
                   ((cmp_freq == best_freq_ff) && (cmp_stamp < best_stamp_ff));

   always_ff @(posedge clock) begin
      if (start) begin
         flags_ff <= '0;
      end else if (cmp_en) begin
         if (cmp_valid) begin
            if (cmp_key == search_key && !flags_ff.hit) begin
               flags_ff.hit <= 1'b1;
               hit_idx_ff   <= cmp_idx;
               hit_value_ff <= cmp_value;
               hit_freq_ff  <= cmp_freq;
            end
            if (better) begin
               flags_ff.victim_found <= 1'b1;
               victim_idx_ff         <= cmp_idx;
               victim_key_ff         <= cmp_key;
               best_freq_ff          <= cmp_freq;
               best_stamp_ff         <= cmp_stamp;
            end
         end else if (!flags_ff.free_found) begin
            flags_ff.free_found <= 1'b1;
            free_idx_ff         <= cmp_idx;
         end
      end
   end

   assign flags      = flags_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_value  = hit_value_ff;
   assign hit_freq   = hit_freq_ff;
   assign free_idx   = free_idx_ff;
   assign victim_idx = victim_idx_ff;
   assign victim_key = victim_key_ff;

endmodule

@@ sv/lfu_cache_table_core.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// key-value cache, least frequently used replacement with oldest-stamp tiebreak
// ----------------------------------------------------------------------------
//  channel | direction | transfer
//  req     | in        | func, key, value
//  rsp     | out       | hit, read_value, evicted, evicted_key
//  csr     | in        | capacity_in_use, written when csr_we is high
//
//  an item passes through accept, then a scan of the entry ram
//  (one read per cycle, registered read data), then one write
//  reset is synchronous: clears valid bits, occupancy, order counter; presets capacity
//  the ram contents need no reset; an entry is only used while its valid bit is set
//  a stalled rsp holds the write step until the output register frees up
// ----------------------------------------------------------------------------
module lfu_cache_table_core #(
   parameter int CAPACITY  = 16,
   parameter int FREQ_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   lfu_req_if.sink                        req,
   lfu_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [lfu_pkg::CAP_CFG_W-1:0]  csr_wdata
);
   import lfu_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (OCC_W > CAP_CFG_W) ? OCC_W : CAP_CFG_W;
   localparam int REC_W = KEY_W + VAL_W + FREQ_BITS + STAMP_W;
   localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_type;

   state_type            state_ff, state_in;
   logic [CAP_CFG_W-1:0] cap_cfg_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [STAMP_W-1:0]   order_ff, order_in;
   logic [CAPACITY-1:0]  valid_ff, valid_in;

   // latched request
   logic                 func_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VAL_W-1:0]     value_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 hit_ff, hit_in;
   logic [VAL_W-1:0]     read_value_ff, read_value_in;
   logic                 evicted_ff, evicted_in;
   logic [KEY_W-1:0]     evicted_key_ff, evicted_key_in;

   // ram ports
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [REC_W-1:0]     ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [REC_W-1:0]     ram_rdata;

   // scan results
   scan_flags_type       flags;
   logic [IDX_W-1:0]     hit_idx, free_idx, victim_idx;
   logic [VAL_W-1:0]     hit_value;
   logic [FREQ_BITS-1:0] hit_freq;
   logic [KEY_W-1:0]     victim_key;

   logic                 req_xfer, out_free, scan_start, cmp_en;
   logic [CNT_W-1:0]     cnt_dec;
   logic [IDX_W-1:0]     cmp_idx;
   logic [CMP_W-1:0]     cap_cfg_ext, cap_eff, occ_ext;
   logic [FREQ_BITS-1:0] bumped_freq;

   assign req_xfer   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign scan_start = req_xfer;

   // compare the entry read in the previous cycle
   assign cmp_en    = (state_ff == S_SCAN) && (cnt_ff != '0);
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign cmp_idx   = cnt_dec[IDX_W-1:0];
   assign ram_raddr = cnt_ff[IDX_W-1:0];

   // capacity above CAPACITY acts as CAPACITY
   assign cap_cfg_ext = CMP_W'(cap_cfg_ff);
   assign occ_ext     = CMP_W'(occ_ff);
   assign cap_eff     = (cap_cfg_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_cfg_ext;

   // frequency saturates but still takes a fresh stamp
   assign bumped_freq = (hit_freq == FREQ_MAX) ? hit_freq : hit_freq + FREQ_BITS'(1);

   lfu_ram #(
      .WIDTH  (REC_W),
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lfu_scan #(
      .FREQ_BITS (FREQ_BITS),
      .IDX_W     (IDX_W)
   ) u_scan (
      .clock      (clock),
      .start      (scan_start),
      .cmp_en     (cmp_en),
      .cmp_idx    (cmp_idx),
      .cmp_valid  (valid_ff[cmp_idx]),
      .cmp_key    (ram_rdata[REC_W-1 -: KEY_W]),
      .cmp_value  (ram_rdata[REC_W-KEY_W-1 -: VAL_W]),
      .cmp_freq   (ram_rdata[STAMP_W +: FREQ_BITS]),
      .cmp_stamp  (ram_rdata[STAMP_W-1:0]),
      .search_key (key_ff),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .hit_value  (hit_value),
      .hit_freq   (hit_freq),
      .free_idx   (free_idx),
      .victim_idx (victim_idx),
      .victim_key (victim_key)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      occ_in         = occ_ff;
      order_in       = order_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      hit_in         = hit_ff;
      read_value_in  = read_value_ff;
      evicted_in     = evicted_ff;
      evicted_key_in = evicted_key_ff;
      ram_we         = 1'b0;
      ram_waddr      = hit_idx;
      ram_wdata      = {key_ff, hit_value, bumped_freq, order_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_SCAN;
               cnt_in   = '0;
            end
         end
         S_SCAN: begin
            // last entry compared when the counter has reached CAPACITY
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               state_in = S_WRITE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_WRITE: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               hit_in         = flags.hit;
               read_value_in  = '0;
               evicted_in     = 1'b0;
               evicted_key_in = '0;
               if (func_ff == FUNC_GET) begin
                  if (flags.hit) begin
                     read_value_in = hit_value;
                     ram_we        = 1'b1;
                     order_in      = order_ff + STAMP_W'(1);
                  end
               end else if (cap_eff != '0) begin
                  ram_we   = 1'b1;
                  order_in = order_ff + STAMP_W'(1);
                  if (flags.hit) begin
                     // update in place
                     ram_wdata = {key_ff, value_ff, bumped_freq, order_ff};
                  end else begin
                     ram_wdata = {key_ff, value_ff, FREQ_BITS'(1), order_ff};
                     if (occ_ext < cap_eff && flags.free_found) begin
                        ram_waddr = free_idx;
                        occ_in    = occ_ff + OCC_W'(1);
                     end else if (flags.victim_found) begin
                        ram_waddr      = victim_idx;
                        evicted_in     = 1'b1;
                        evicted_key_in = victim_key;
                     end else begin
                        ram_waddr = '0;
                        occ_in    = occ_ff + OCC_W'(1);
                     end
                     valid_in[ram_waddr] = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         order_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cap_cfg_ff   <= CAP_CFG_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         order_ff     <= order_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_cfg_ff <= csr_wdata;
         end
      end
      hit_ff         <= hit_in;
      read_value_ff  <= read_value_in;
      evicted_ff     <= evicted_in;
      evicted_key_ff <= evicted_key_in;
      if (req_xfer) begin
         func_ff  <= req.func;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.read_value  = read_value_ff;
   assign rsp.evicted     = evicted_ff;
   assign rsp.evicted_key = evicted_key_ff;

`ifndef SYNTHESIS
   // a request transfer always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_SCAN)
      else $error("scan did not start after request transfer");

   // the entry ram is only written in the write step
   a_write_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_WRITE) && out_free)
      else $error("ram write outside write step");

   // occupancy tracks the number of valid entries
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid bits");
`endif

endmodule
